/* design/edsh_pkg.sv */
package edsh_pkg;

  localparam int unsigned MAX_LEN_DEF    = 1024;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned NTAB           = 6;
  localparam int unsigned NPAIR          = 16;
  localparam int unsigned QUAL_OFFSET    = 33;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;
  localparam logic [1:0] BASE_A = 2'd0;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - 8'd32 : c;
  endfunction

  // bit 2 set: not a plain base letter
  function automatic logic [2:0] base_code(input logic [7:0] c);
    case (c)
      CH_A: base_code = {1'b0, BASE_A};
      CH_C: base_code = {1'b0, BASE_C};
      CH_G: base_code = {1'b0, BASE_G};
      CH_T: base_code = {1'b0, BASE_T};
      default: base_code = 3'b100;
    endcase
  endfunction

  // {valid, ref, read}
  function automatic logic [4:0] encode_base(input logic [7:0] refc, input logic [7:0] readc,
                                             input logic [7:0] qchar, input logic [8:0] minq);
    logic signed [9:0] q;
    logic signed [9:0] mq;
    logic [7:0] r;
    logic [7:0] b;
    logic [2:0] rc;
    logic [2:0] bc;
    q  = $signed({2'b00, qchar}) - 10'sd33;
    mq = $signed({minq[8], minq});
    r  = upcase(refc);
    b  = upcase(readc);
    if (r == CH_M) r = b;
    rc = base_code(r);
    bc = base_code(b);
    if (q < mq || upcase(refc) == CH_S || upcase(refc) == CH_I || rc[2] || bc[2]) begin
      encode_base = 5'd0;
    end else begin
      encode_base = {1'b1, rc[1:0], bc[1:0]};
    end
  endfunction

  // bit0 5pS, bit1 3pS, bit2 5pD, bit3 3pD
  function automatic logic [3:0] end_eval(input logic [4:0] e, input logic first,
                                          input logic rev);
    logic [1:0] rc;
    logic [1:0] bc;
    logic [3:0] f;
    rc = rev ? ~e[3:2] : e[3:2];
    bc = rev ? ~e[1:0] : e[1:0];
    f  = 4'd0;
    if (e[4]) begin
      if (rc == BASE_C && bc == BASE_T) begin
        if (first == !rev) f = f | 4'b0101;
        else f = f | 4'b0010;
      end
      if (rc == BASE_G && bc == BASE_A && first == rev) f = f | 4'b1000;
    end
    end_eval = f;
  endfunction

endpackage

/* design/edsh_in_if.sv */
interface edsh_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ref_code;
  logic [7:0] read_code;
  logic [7:0] quality_char;
  logic       reverse_strand;
  logic       last_base;
  logic [2:0] table_select;
  logic [9:0] position;
  logic [3:0] pair_index;

  modport source (output valid, op, ref_code, read_code, quality_char, reverse_strand,
                  last_base, table_select, position, pair_index, input ready);
  modport sink (input valid, op, ref_code, read_code, quality_char, reverse_strand,
                last_base, table_select, position, pair_index, output ready);
endinterface

/* design/edsh_out_if.sv */
interface edsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;
  logic        status;

  modport source (output valid, count, status, input ready);
  modport sink (input valid, count, status, output ready);
endinterface

/* design/end_damage_substitution_histogram.sv */
// channel  | dir | handshake    | payload
// in_i     | in  | valid/ready  | op, ref_code, read_code, quality_char, reverse_strand,
//          |     |              | last_base, table_select, position, pair_index
// out_o    | out | valid/ready  | count, status
// cfg      | in  | cfg_we_i     | cfg_wdata_i (min_quality)
//
// a readout reads the histogram RAM; in S_RO its result is loaded into the output register
// a final base walks the buffered read: end checks in S_E0, S_E1 and S_E2, then S_BRD and
// S_BASE for each base, and for a counted base S_HRD per table and S_HWR per enabled one
// after reset a clearing pass writes zero to all 6*MAX_LEN*16 counters, one per cycle,
// while no item is taken; cfg writes are taken at any time
// one item at a time; a pending result holds in the output register until taken
module end_damage_substitution_histogram #(
  parameter int unsigned MAX_LEN    = edsh_pkg::MAX_LEN_DEF,
  parameter int unsigned COUNT_BITS = edsh_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  edsh_in_if.sink    in_i,
  edsh_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i
);
  localparam int unsigned BAW    = $clog2(MAX_LEN);
  localparam int unsigned LW     = $clog2(MAX_LEN + 2);
  localparam int unsigned HDEPTH = edsh_pkg::NTAB * MAX_LEN * edsh_pkg::NPAIR;
  localparam int unsigned HAW    = $clog2(HDEPTH);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RO    = 10'b0000000100,
    S_E0    = 10'b0000001000,
    S_E1    = 10'b0000010000,
    S_E2    = 10'b0000100000,
    S_BRD   = 10'b0001000000,
    S_BASE  = 10'b0010000000,
    S_HRD   = 10'b0100000000,
    S_HWR   = 10'b1000000000
  } state_e;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic            strand_q, strand_d;
  logic [3:0]      flags_q, flags_d;
  logic [8:0]      minq_q;
  logic [BAW-1:0]  idx_q, idx_d;
  logic [2:0]      tbl_q, tbl_d;
  logic [4:0]      first_q, first_d;
  logic [3:0]      pair_q, pair_d;
  logic [BAW-1:0]  d5_q, d5_d, d3_q, d3_d;
  logic [HAW-1:0]  clr_q, clr_d;
  logic            ro_ok_q, ro_ok_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_count_q, out_count_d;
  logic            out_status_q, out_status_d;

  logic                  buf_we;
  logic [BAW-1:0]        buf_waddr, buf_raddr;
  logic [4:0]            buf_wdata, buf_rdata;
  logic                  h_we;
  logic [HAW-1:0]        h_waddr, h_raddr, h_walk;
  logic [COUNT_BITS-1:0] h_wdata, h_rdata;

  logic [15:0]     pos_ext;
  logic            ro_ok;
  logic            tbl_en;
  logic            last_idx;
  logic [1:0]      rc, bc;
  logic [BAW-1:0]  dist_hi;

  function automatic logic [HAW-1:0] haddr(input logic [2:0] t, input logic [BAW-1:0] p,
                                           input logic [3:0] pr);
    haddr = HAW'(t) * HAW'(MAX_LEN * edsh_pkg::NPAIR) + HAW'({p, pr});
  endfunction

  edsh_buf_ram #(.DEPTH(MAX_LEN), .AW(BAW)) u_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(buf_waddr),
    .wdata_i(buf_wdata),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  edsh_hist_ram #(.DEPTH(HDEPTH), .AW(HAW), .DW(COUNT_BITS)) u_hist (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  assign pos_ext  = 16'(in_i.position);
  assign ro_ok    = (in_i.table_select < 3'(edsh_pkg::NTAB)) && (pos_ext < 16'(MAX_LEN));
  assign h_walk   = haddr(tbl_q, tbl_q[0] ? d3_q : d5_q, pair_q);
  assign last_idx = (LW'(idx_q) == len_q - LW'(1));
  assign rc       = strand_q ? ~buf_rdata[3:2] : buf_rdata[3:2];
  assign bc       = strand_q ? ~buf_rdata[1:0] : buf_rdata[1:0];
  assign dist_hi  = BAW'(len_q - LW'(1) - LW'(idx_q));

  always_comb begin
    case (tbl_q)
      3'd0, 3'd1: tbl_en = 1'b1;
      3'd2: tbl_en = flags_q[3];
      3'd3: tbl_en = flags_q[2];
      3'd4: tbl_en = flags_q[1];
      3'd5: tbl_en = flags_q[0];
      default: tbl_en = 1'b0;
    endcase
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.count  = out_count_q;
  assign out_o.status = out_status_q;

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    strand_d     = strand_q;
    flags_d      = flags_q;
    idx_d        = idx_q;
    tbl_d        = tbl_q;
    first_d      = first_q;
    pair_d       = pair_q;
    d5_d         = d5_q;
    d3_d         = d3_q;
    clr_d        = clr_q;
    ro_ok_d      = ro_ok_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    in_i.ready   = 1'b0;
    buf_we       = 1'b0;
    buf_waddr    = len_q[BAW-1:0];
    buf_wdata    = edsh_pkg::encode_base(in_i.ref_code, in_i.read_code, in_i.quality_char,
                                         minq_q);
    buf_raddr    = idx_q;
    h_we         = 1'b0;
    h_waddr      = h_walk;
    h_wdata      = (&h_rdata) ? h_rdata : h_rdata + COUNT_BITS'(1);
    h_raddr      = h_walk;

    case (state_q)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
        clr_d   = clr_q + HAW'(1);
        if (clr_q == HAW'(HDEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_i.ready = ~out_valid_q | out_o.ready;
        if (in_i.valid && in_i.ready) begin
          if (in_i.op) begin
            h_raddr = haddr(in_i.table_select, pos_ext[BAW-1:0], in_i.pair_index);
            ro_ok_d = ro_ok;
            state_d = S_RO;
          end else begin
            if (len_q == '0) strand_d = in_i.reverse_strand;
            if (len_q < LW'(MAX_LEN)) buf_we = 1'b1;
            if (len_q <= LW'(MAX_LEN)) len_d = len_q + LW'(1);
            if (in_i.last_base) begin
              if (len_d > LW'(MAX_LEN)) begin
                out_valid_d  = 1'b1;
                out_count_d  = '0;
                out_status_d = 1'b1;
                len_d        = '0;
              end else begin
                state_d = S_E0;
              end
            end
          end
        end
      end
      S_RO: begin
        out_valid_d  = 1'b1;
        out_count_d  = ro_ok_q ? 32'(h_rdata) : 32'd0;
        out_status_d = 1'b0;
        state_d      = S_IDLE;
      end
      S_E0: begin
        buf_raddr = '0;
        state_d   = S_E1;
      end
      S_E1: begin
        buf_raddr = BAW'(len_q - LW'(1));
        first_d   = buf_rdata;
        state_d   = S_E2;
      end
      S_E2: begin
        flags_d = edsh_pkg::end_eval(first_q, 1'b1, strand_q)
                | edsh_pkg::end_eval(buf_rdata, 1'b0, strand_q);
        idx_d   = '0;
        state_d = S_BRD;
      end
      S_BRD: begin
        state_d = S_BASE;
      end
      S_BASE: begin
        if (buf_rdata[4]) begin
          pair_d  = {rc, bc};
          d5_d    = strand_q ? dist_hi : idx_q;
          d3_d    = strand_q ? idx_q : dist_hi;
          tbl_d   = '0;
          state_d = S_HRD;
        end else if (last_idx) begin
          out_valid_d  = 1'b1;
          out_count_d  = '0;
          out_status_d = 1'b0;
          len_d        = '0;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + BAW'(1);
          state_d = S_BRD;
        end
      end
      S_HRD, S_HWR: begin
        if (state_q == S_HWR) h_we = 1'b1;
        if (state_q == S_HRD && tbl_en) begin
          state_d = S_HWR;
        end else if (tbl_q != 3'(edsh_pkg::NTAB - 1)) begin
          tbl_d   = tbl_q + 3'd1;
          state_d = S_HRD;
        end else if (last_idx) begin
          out_valid_d  = 1'b1;
          out_count_d  = '0;
          out_status_d = 1'b0;
          len_d        = '0;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + BAW'(1);
          state_d = S_BRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      len_q        <= '0;
      strand_q     <= 1'b0;
      flags_q      <= '0;
      minq_q       <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      strand_q     <= strand_d;
      flags_q      <= flags_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) minq_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    tbl_q        <= tbl_d;
    first_q      <= first_d;
    pair_q       <= pair_d;
    d5_q         <= d5_d;
    d3_q         <= d3_d;
    ro_ok_q      <= ro_ok_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end
endmodule

/* design/edsh_buf_ram.sv */
module edsh_buf_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [4:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [4:0]    rdata_o
);
  logic [4:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* design/edsh_hist_ram.sv */
module edsh_hist_ram #(
  parameter int unsigned DEPTH = 98304,
  parameter int unsigned AW    = 17,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* design/edsh_chk.sv */
module edsh_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_count,
  input logic        out_status
);
  a_status_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status |-> out_count == 32'd0)
    else $error("discard result with nonzero count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("stalled result changed");

  a_readout_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op |=> ##1 out_valid)
    else $error("readout result missing");

  a_mid_base_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !in_op && !in_last |=> !out_valid)
    else $error("result after non-final base");
endmodule

bind end_damage_substitution_histogram edsh_chk u_edsh_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_op     (in_i.op),
  .in_last   (in_i.last_base),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_count (out_o.count),
  .out_status(out_o.status)
);
